>>> rtl/core/lrf_pkg.sv
package lrf_pkg;

  localparam int SIDE    = 512;
  localparam int COORD_W = 9;
  localparam int COUNT_W = 10;
  localparam int ROW_W   = $clog2(SIDE);
  localparam int SPAN_W  = COORD_W + 2;
  localparam int D_W     = COORD_W + 3;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ROW_W-1:0]   row_idx_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_READ,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SP_IDLE,
    SP_SPAN,
    SP_ORIENT,
    SP_WALK
  } step_state_t;

  typedef struct packed {
    coord_t xa;
    coord_t ya;
    coord_t xb;
    coord_t yb;
  } line_t;

  typedef struct packed {
    logic   valid;
    logic   last;
    coord_t col;
    coord_t row;
  } pix_t;

  function automatic logic in_frame(coord_t col, coord_t row);
    return (32'(col) < SIDE) && (32'(row) < SIDE);
  endfunction

endpackage

>>> rtl/core/lrf_if.sv
interface lrf_cmd_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            command;
  logic [lrf_pkg::COORD_W-1:0] x_start;
  logic [lrf_pkg::COORD_W-1:0] y_start;
  logic [lrf_pkg::COORD_W-1:0] x_end;
  logic [lrf_pkg::COORD_W-1:0] y_end;

  modport source (output valid, command, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, command, x_start, y_start, x_end, y_end, output ready);
endinterface

interface lrf_res_if;
  logic                        valid;
  logic                        ready;
  logic                        pixel_value;
  logic [lrf_pkg::COUNT_W-1:0] pixels_drawn;

  modport source (output valid, pixel_value, pixels_drawn, input ready);
  modport sink   (input valid, pixel_value, pixels_drawn, output ready);
endinterface

>>> rtl/core/lrf_ram.sv
module lrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/lrf_stepper.sv
module lrf_stepper (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  lrf_pkg::line_t line,
  output lrf_pkg::pix_t  pix
);
  import lrf_pkg::*;

  step_state_t state_r, state_nxt;

  coord_t xa_r, ya_r, xb_r, yb_r;
  coord_t dx_r, dy_r;
  coord_t maj_r, maj_end_r, min_r;
  logic   x_major_r, step_neg_r;
  logic signed [D_W-1:0] d_r;
  logic [SPAN_W-1:0] inc_r, dec_r;

  logic   x_major, swap;
  coord_t maj0, end0, min0, far0, major, minor, span_diff;
  logic   last;

  always_comb begin
    x_major = dx_r >= dy_r;
    if (x_major) begin
      swap  = xa_r > xb_r;
      maj0  = swap ? xb_r : xa_r;
      end0  = swap ? xa_r : xb_r;
      min0  = swap ? yb_r : ya_r;
      far0  = swap ? ya_r : yb_r;
      major = dx_r;
      minor = dy_r;
    end else begin
      swap  = ya_r > yb_r;
      maj0  = swap ? yb_r : ya_r;
      end0  = swap ? ya_r : yb_r;
      min0  = swap ? xb_r : xa_r;
      far0  = swap ? xa_r : xb_r;
      major = dy_r;
      minor = dx_r;
    end
    span_diff = major - minor;
  end

  assign last = (maj_r == maj_end_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SP_IDLE:   if (start) state_nxt = SP_SPAN;
      SP_SPAN:   state_nxt = SP_ORIENT;
      SP_ORIENT: state_nxt = SP_WALK;
      SP_WALK:   if (last) state_nxt = SP_IDLE;
      default:   state_nxt = SP_IDLE;
    endcase
  end

  always_comb begin
    pix.valid = (state_r == SP_WALK);
    pix.last  = last;
    pix.col   = x_major_r ? maj_r : min_r;
    pix.row   = x_major_r ? min_r : maj_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SP_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      SP_IDLE: begin
        if (start) begin
          xa_r <= line.xa;
          ya_r <= line.ya;
          xb_r <= line.xb;
          yb_r <= line.yb;
        end
      end
      SP_SPAN: begin
        dx_r <= (xb_r > xa_r) ? xb_r - xa_r : xa_r - xb_r;
        dy_r <= (yb_r > ya_r) ? yb_r - ya_r : ya_r - yb_r;
      end
      SP_ORIENT: begin
        x_major_r  <= x_major;
        maj_r      <= maj0;
        maj_end_r  <= end0;
        min_r      <= min0;
        step_neg_r <= far0 < min0;
        d_r        <= $signed({3'b000, major}) - $signed({2'b00, minor, 1'b0});
        inc_r      <= {1'b0, span_diff, 1'b0};
        dec_r      <= {1'b0, minor, 1'b0};
      end
      SP_WALK: begin
        maj_r <= maj_r + 1'b1;
        if (d_r[D_W-1]) begin
          min_r <= step_neg_r ? min_r - 1'b1 : min_r + 1'b1;
          d_r   <= d_r + $signed({1'b0, inc_r});
        end else begin
          d_r   <= d_r - $signed({1'b0, dec_r});
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/line_rasterizer_framebuffer.sv
// Draw: one pixel per cycle, row read-modify-write on the frame memory,
// back-to-back same-row hits forwarded. Clear: one memory row per cycle. Unused code: 3.
// One command at a time; the next transfer is taken once the result is registered.
// Reset is synchronous: a clearing pass blanks the memory, input held off.
module line_rasterizer_framebuffer (
  input logic       clk,
  input logic       rst_n,
  lrf_cmd_if.sink   in_chan,
  lrf_res_if.source out_chan
);
  import lrf_pkg::*;

  state_t state_r, state_nxt;

  row_idx_t clr_cnt_r;
  logic     clr_resp_r;

  logic     rd_ok_r;
  row_idx_t rd_col_r;
  logic     res_value_r;
  count_t   res_count_r;

  logic     s1_valid_r, s1_last_r, s1_in_r;
  row_idx_t s1_col_r, s1_row_r;

  logic            wr_valid_r;
  row_idx_t        wr_row_r;
  logic [SIDE-1:0] wr_data_r;

  logic   out_valid_r, out_value_r;
  count_t out_count_r;

  logic     accept;
  cmd_t     cmd;
  line_t    line;
  pix_t     pix;
  logic     pix_in;
  logic     clr_last;
  logic     out_free;

  logic            ram_wr_en, ram_rd_en;
  row_idx_t        ram_wr_addr, ram_rd_addr;
  logic [SIDE-1:0] ram_wr_data, ram_rd_data;
  logic [SIDE-1:0] row_base, row_merged;

  assign accept   = in_chan.valid && in_chan.ready;
  assign cmd      = cmd_t'(in_chan.command);
  assign line     = '{xa: in_chan.x_start, ya: in_chan.y_start,
                      xb: in_chan.x_end,   yb: in_chan.y_end};
  assign pix_in   = in_frame(pix.col, pix.row);
  assign clr_last = (clr_cnt_r == ROW_W'(SIDE - 1));
  assign out_free = !out_valid_r || out_chan.ready;

  lrf_stepper u_stepper (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept && (cmd == CMD_DRAW)),
    .line  (line),
    .pix   (pix)
  );

  lrf_ram #(
    .WIDTH (SIDE),
    .DEPTH (SIDE)
  ) u_frame (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // previous pixel's write lands after this row was read: forward it
  assign row_base   = (wr_valid_r && (wr_row_r == s1_row_r)) ? wr_data_r : ram_rd_data;
  assign row_merged = row_base | (SIDE'(1'b1) << s1_col_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = clr_resp_r ? ST_DONE : ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_DRAW:  state_nxt = ST_DRAW;
            CMD_READ:  state_nxt = ST_READ;
            CMD_NONE:  state_nxt = ST_DONE;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DRAW:  if (s1_valid_r && s1_last_r) state_nxt = ST_DONE;
      ST_READ:  state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = (state_r == ST_IDLE);
    ram_wr_en     = (state_r == ST_CLEAR) || (s1_valid_r && s1_in_r);
    ram_wr_addr   = (state_r == ST_CLEAR) ? clr_cnt_r : s1_row_r;
    ram_wr_data   = (state_r == ST_CLEAR) ? '0 : row_merged;
    ram_rd_en     = (pix.valid && pix_in) || (accept && (cmd == CMD_READ));
    ram_rd_addr   = pix.valid ? ROW_W'(pix.row) : ROW_W'(in_chan.y_start);
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.pixel_value  = out_value_r;
  assign out_chan.pixels_drawn = out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_resp_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      wr_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= (state_r == ST_CLEAR) ? clr_cnt_r + 1'b1 : '0;
      s1_valid_r <= pix.valid;
      wr_valid_r <= s1_valid_r && s1_in_r;
      if (accept) begin
        clr_resp_r <= (cmd == CMD_CLEAR);
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= pix.last;
    s1_in_r   <= pix_in;
    s1_col_r  <= ROW_W'(pix.col);
    s1_row_r  <= ROW_W'(pix.row);
    wr_row_r  <= s1_row_r;
    wr_data_r <= row_merged;
    if (accept) begin
      rd_ok_r     <= in_frame(in_chan.x_start, in_chan.y_start);
      rd_col_r    <= ROW_W'(in_chan.x_start);
      res_value_r <= 1'b0;
      res_count_r <= '0;
    end else if (state_r == ST_READ) begin
      res_value_r <= rd_ok_r & ram_rd_data[rd_col_r];
    end else if (s1_valid_r && s1_in_r) begin
      res_count_r <= res_count_r + 1'b1;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_value_r <= res_value_r;
      out_count_r <= res_count_r;
    end
  end

endmodule
